@@ rtl/core/mwde_pkg.sv @@
// Shared constants for the moving window deconvolution energy block.
`default_nettype none
package mwde_pkg;
    localparam int MAX_WINDOW = 1024;
    localparam int PTR_W      = $clog2(MAX_WINDOW);
    localparam int MAX_TRACE  = 65536;
    localparam int CNT_W      = $clog2(MAX_TRACE) + 1;
    localparam int DIGIT_W    = 26;
    localparam int COEF_W     = 25;
    localparam int CELL_W     = DIGIT_W + COEF_W + 2;
    localparam int ACC_W      = 58;
    localparam int DIV_W      = ACC_W + 1;
    localparam int QUO_W      = DIV_W + 1;

    localparam logic [2:0] REG_WINDOW_M   = 3'd0;
    localparam logic [2:0] REG_WINDOW_L   = 3'd1;
    localparam logic [2:0] REG_INV_TAU    = 3'd2;
    localparam logic [2:0] REG_INV_L      = 3'd3;
    localparam logic [2:0] REG_AMP_START  = 3'd4;
    localparam logic [2:0] REG_AMP_STOP   = 3'd5;
    localparam logic [2:0] REG_BASE_START = 3'd6;
    localparam logic [2:0] REG_BASE_STOP  = 3'd7;
endpackage
`default_nettype wire

@@ rtl/core/mwde_mul_cell.sv @@
// Multiplier cell: one signed digit times a coefficient plus the carry of its neighbour.
`default_nettype none
module mwde_mul_cell (
    input  wire                                 i_clk,
    input  wire signed [mwde_pkg::DIGIT_W:0]    i_digit,
    input  wire        [mwde_pkg::COEF_W-1:0]   i_coef,
    input  wire signed [mwde_pkg::DIGIT_W:0]    i_carry,
    output logic signed [mwde_pkg::CELL_W-1:0]  o_sum
);
    import mwde_pkg::*;

    logic signed [CELL_W-1:0] r_sum;
    logic signed [CELL_W-1:0] n_sum;

    always_comb begin
        n_sum = CELL_W'(i_digit * $signed({1'b0, i_coef})) + CELL_W'(i_carry);
    end

    always_ff @(posedge i_clk) begin
        r_sum <= n_sum;
    end

    assign o_sum = r_sum;
endmodule
`default_nettype wire

@@ rtl/core/mwde_div.sv @@
// Bit-serial divider giving a window average rounded to nearest, ties away from zero.
`default_nettype none
module mwde_div (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_start,
    input  wire signed [mwde_pkg::ACC_W-1:0]    i_sum,
    input  wire        [15:0]                   i_count,
    output logic                                o_done,
    output logic signed [mwde_pkg::QUO_W-1:0]   o_quot
);
    import mwde_pkg::*;

    logic [DIV_W-1:0] r_quo;
    logic [15:0]      r_rem;
    logic [15:0]      r_den;
    logic             r_neg;
    logic [6:0]       r_steps;
    logic             r_busy;
    logic             r_done;
    logic [16:0]      trial;
    logic             fits;
    logic [DIV_W-1:0] mag;

    always_comb begin
        mag   = i_sum[ACC_W-1] ? DIV_W'(-i_sum) : DIV_W'(i_sum);
        trial = {r_rem, r_quo[DIV_W-1]};
        fits  = trial >= {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_steps <= 7'(DIV_W);
                r_quo   <= mag + DIV_W'(i_count[15:1]);
                r_rem   <= '0;
                r_den   <= i_count;
                r_neg   <= i_sum[ACC_W-1];
            end else if (r_busy) begin
                r_rem   <= fits ? 16'(trial - {1'b0, r_den}) : trial[15:0];
                r_quo   <= {r_quo[DIV_W-2:0], fits};
                r_steps <= r_steps - 7'd1;
                if (r_steps == 7'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_neg ? -$signed({1'b0, r_quo}) : $signed({1'b0, r_quo});

`ifndef ASSERT_OFF
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy))
        else $error("divider finished without running");
    a_steps_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_steps != 7'd0 && r_steps <= 7'(DIV_W)))
        else $error("divider step count out of range");
    a_rem_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !$past(i_start)) |-> (r_rem < r_den))
        else $error("divider remainder not reduced");
`endif
endmodule
`default_nettype wire

@@ rtl/core/moving_window_deconvolution_energy.sv @@
// Top level of the moving window deconvolution energy filter.
//
//   channel   direction  transfer when            contents
//   s stream  in         i_s_tvalid & o_s_tready  sample, last in tlast
//   m stream  out        o_m_tvalid & i_m_tready  index, mwd, energy; last in tlast, window_error
//   apb       in         psel&penable&pwrite      eight filter registers at 4*i
//
// A sample is taken only in the idle state, so the block takes no new sample before the last has
// passed states P0 to P3 and DONE, in which two chained multiplier cells form the rounded products
// of the step sum with 1/L and of the window sum with 1/tau.
// The last sample of a valid trace adds two serial divisions.
// The delay lines are memories read under the sample count, so reset clears only control.
// A new sample is taken while the previous result waits on a stalled output.
`default_nettype none
module moving_window_deconvolution_energy (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_tvalid,
    output logic        o_s_tready,
    input  wire  [15:0] i_s_tdata,   // sample[15:0]
    input  wire         i_s_tlast,
    output logic        o_m_tvalid,
    input  wire         i_m_tready,
    output logic [95:0] o_m_tdata,   // index[15:0], mwd[55:16], energy[95:56]
    output logic        o_m_tlast,
    output logic        o_m_tuser,   // window_error[0]
    input  wire         i_psel,
    input  wire         i_penable,
    input  wire         i_pwrite,
    input  wire  [4:0]  i_paddr,
    input  wire  [31:0] i_pwdata,
    output logic [31:0] o_prdata,
    output logic        o_pready
);
    import mwde_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_P0   = 3'd1;
    localparam logic [2:0] ST_P1   = 3'd2;
    localparam logic [2:0] ST_P2   = 3'd3;
    localparam logic [2:0] ST_P3   = 3'd4;
    localparam logic [2:0] ST_DIVA = 3'd5;
    localparam logic [2:0] ST_DIVB = 3'd6;
    localparam logic [2:0] ST_DONE = 3'd7;

    logic [10:0] r_win_m, r_win_l;
    logic [24:0] r_inv_tau, r_inv_l;
    logic [15:0] r_amp_start, r_amp_stop, r_base_start, r_base_stop;

    logic [2:0]  r_state, n_state;
    logic signed [15:0] r_x;
    logic        r_last, r_xuse, r_duse;
    logic signed [15:0] r_xold_mem;
    logic signed [39:0] r_dold_mem;
    logic [PTR_W-1:0] r_pos;
    logic [CNT_W-1:0] r_count;
    logic signed [27:0] r_wsum;
    logic signed [51:0] r_ssum;
    logic signed [ACC_W-1:0] r_amp, r_base;
    logic [DIGIT_W-1:0] r_l0s, r_l0w;
    logic signed [39:0] r_mwd;
    logic signed [QUO_W-1:0] r_qa;
    logic [15:0] r_p_index;
    logic signed [39:0] r_p_mwd;
    logic        r_p_last, r_p_err;
    logic [39:0] r_p_energy;
    logic        r_ovalid;
    logic [95:0] r_o_tdata;
    logic        r_o_tlast, r_o_tuser;

    logic signed [15:0] m_sample [MAX_WINDOW];
    logic signed [39:0] m_step   [MAX_WINDOW];

    logic        accept, cfg_wr;
    logic [10:0] m_eff, l_eff;
    logic [PTR_W-1:0] rd_m, rd_l;
    logic signed [51:0] wext;
    logic signed [DIGIT_W:0] c0_digit, c1_digit, c0_carry, c1_carry;
    logic [COEF_W-1:0] c0_coef, c1_coef;
    logic signed [CELL_W-1:0] c0_sum, c1_sum;
    logic signed [54:0] mwd_raw;
    logic signed [39:0] mwd_sat, tau_term, dm40;
    logic signed [16:0] dx;
    logic signed [40:0] dm;
    logic signed [15:0] xo;
    logic signed [39:0] dold;
    logic        ovf, in_amp, in_base, err;
    logic [CNT_W-1:0] n_len;
    logic signed [ACC_W-1:0] n_amp, n_base;
    logic        div_start, div_done;
    logic signed [ACC_W-1:0] div_sum;
    logic [15:0] div_cnt;
    logic signed [QUO_W-1:0] div_quot;
    logic signed [QUO_W:0] diff;
    logic [QUO_W:0] adiff;

    assign accept = i_s_tvalid && o_s_tready;
    assign cfg_wr = i_psel && i_penable && i_pwrite;
    assign o_s_tready = r_state == ST_IDLE;
    assign o_pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_m      <= 11'd16;
            r_win_l      <= 11'd16;
            r_inv_tau    <= 25'd16777;
            r_inv_l      <= 25'd1048576;
            r_amp_start  <= '0;
            r_amp_stop   <= '0;
            r_base_start <= '0;
            r_base_stop  <= '0;
        end else if (cfg_wr) begin
            case (i_paddr[4:2])
                REG_WINDOW_M:   r_win_m      <= i_pwdata[10:0];
                REG_WINDOW_L:   r_win_l      <= i_pwdata[10:0];
                REG_INV_TAU:    r_inv_tau    <= i_pwdata[24:0];
                REG_INV_L:      r_inv_l      <= i_pwdata[24:0];
                REG_AMP_START:  r_amp_start  <= i_pwdata[15:0];
                REG_AMP_STOP:   r_amp_stop   <= i_pwdata[15:0];
                REG_BASE_START: r_base_start <= i_pwdata[15:0];
                REG_BASE_STOP:  r_base_stop  <= i_pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (i_paddr[4:2])
            REG_WINDOW_M:   o_prdata = 32'(r_win_m);
            REG_WINDOW_L:   o_prdata = 32'(r_win_l);
            REG_INV_TAU:    o_prdata = 32'(r_inv_tau);
            REG_INV_L:      o_prdata = 32'(r_inv_l);
            REG_AMP_START:  o_prdata = 32'(r_amp_start);
            REG_AMP_STOP:   o_prdata = 32'(r_amp_stop);
            REG_BASE_START: o_prdata = 32'(r_base_start);
            REG_BASE_STOP:  o_prdata = 32'(r_base_stop);
            default:        o_prdata = '0;
        endcase
    end

    always_comb begin
        m_eff = (r_win_m == 11'd0) ? 11'd1 :
                (r_win_m > 11'(MAX_WINDOW)) ? 11'(MAX_WINDOW) : r_win_m;
        l_eff = (r_win_l == 11'd0) ? 11'd1 :
                (r_win_l > 11'(MAX_WINDOW)) ? 11'(MAX_WINDOW) : r_win_l;
        rd_m  = r_pos - m_eff[PTR_W-1:0];
        rd_l  = r_pos - l_eff[PTR_W-1:0];
        wext  = 52'(r_wsum);

        if (r_state == ST_P0) begin
            c0_digit = $signed({1'b0, r_ssum[DIGIT_W-1:0]});
            c0_coef  = r_inv_l;
            c0_carry = 27'sd8388608;
        end else begin
            c0_digit = $signed({1'b0, wext[DIGIT_W-1:0]});
            c0_coef  = r_inv_tau;
            c0_carry = 27'sd32768;
        end
        c1_carry = c0_sum[CELL_W-1:DIGIT_W];
        if (r_state == ST_P1) begin
            c1_digit = 27'($signed(r_ssum[51:DIGIT_W]));
            c1_coef  = r_inv_l;
        end else begin
            c1_digit = 27'($signed(wext[51:DIGIT_W]));
            c1_coef  = r_inv_tau;
        end
    end

    mwde_mul_cell u_cell0 (
        .i_clk(i_clk), .i_digit(c0_digit), .i_coef(c0_coef), .i_carry(c0_carry),
        .o_sum(c0_sum)
    );

    mwde_mul_cell u_cell1 (
        .i_clk(i_clk), .i_digit(c1_digit), .i_coef(c1_coef), .i_carry(c1_carry),
        .o_sum(c1_sum)
    );

    always_comb begin
        mwd_raw  = $signed({c1_sum, r_l0s[25:24]});
        if (mwd_raw > 55'sd549755813887) begin
            mwd_sat = 40'sh7FFFFFFFFF;
        end else if (mwd_raw < -55'sd549755813888) begin
            mwd_sat = -40'sh8000000000;
        end else begin
            mwd_sat = mwd_raw[39:0];
        end
        tau_term = $signed({c1_sum[29:0], r_l0w[25:16]});
        xo       = r_xuse ? r_xold_mem : 16'sd0;
        dold     = r_duse ? r_dold_mem : 40'sd0;
        dx       = 17'(r_x) - 17'(xo);
        dm       = $signed({dx, 8'd0}) + 41'(tau_term);
        dm40     = dm[39:0];
        ovf      = r_count[CNT_W-1];
        n_len    = r_count + CNT_W'(1);
        in_amp   = !ovf && r_count >= CNT_W'(r_amp_start) && r_count < CNT_W'(r_amp_stop);
        in_base  = !ovf && r_count >= CNT_W'(r_base_start) && r_count < CNT_W'(r_base_stop);
        n_amp    = in_amp ? r_amp + ACC_W'(r_mwd) : r_amp;
        n_base   = in_base ? r_base + ACC_W'(r_mwd) : r_base;
        err      = ovf || r_amp_stop <= r_amp_start || r_base_stop <= r_base_start
                   || CNT_W'(r_amp_stop) > n_len || CNT_W'(r_base_stop) > n_len;
        diff     = (QUO_W+1)'(r_qa) - (QUO_W+1)'(div_quot);
        adiff    = diff[QUO_W] ? (QUO_W+1)'(-diff) : (QUO_W+1)'(diff);

        div_start = 1'b0;
        div_sum   = n_amp;
        div_cnt   = r_amp_stop - r_amp_start;
        if (r_state == ST_P3 && r_last && !err) begin
            div_start = 1'b1;
        end else if (r_state == ST_DIVA && div_done) begin
            div_start = 1'b1;
            div_sum   = r_base;
            div_cnt   = r_base_stop - r_base_start;
        end

        n_state = r_state;
        case (r_state)
            ST_IDLE: if (accept) n_state = ST_P0;
            ST_P0:   n_state = ST_P1;
            ST_P1:   n_state = ST_P2;
            ST_P2:   n_state = ST_P3;
            ST_P3:   n_state = (r_last && !err) ? ST_DIVA : ST_DONE;
            ST_DIVA: if (div_done) n_state = ST_DIVB;
            ST_DIVB: if (div_done) n_state = ST_DONE;
            ST_DONE: if (!r_ovalid || i_m_tready) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    mwde_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start), .i_sum(div_sum),
        .i_count(div_cnt), .o_done(div_done), .o_quot(div_quot)
    );

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_xold_mem <= m_sample[rd_m];
            r_dold_mem <= m_step[rd_l];
        end
        if (r_state == ST_P3) begin
            m_sample[r_pos] <= r_x;
            m_step[r_pos]   <= dm40;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_x    <= $signed(i_s_tdata);
            r_last <= i_s_tlast;
            r_xuse <= r_count >= CNT_W'(m_eff);
            r_duse <= r_count >= CNT_W'(l_eff);
        end
        if (r_state == ST_P1) r_l0s <= c0_sum[DIGIT_W-1:0];
        if (r_state == ST_P2) begin
            r_l0w <= c0_sum[DIGIT_W-1:0];
            r_mwd <= mwd_sat;
        end
        if (r_state == ST_P3) begin
            r_p_index  <= r_count[15:0];
            r_p_mwd    <= r_mwd;
            r_p_last   <= r_last;
            r_p_err    <= r_last && err;
            r_p_energy <= '0;
        end
        if (r_state == ST_DIVA && div_done) r_qa <= div_quot;
        if (r_state == ST_DIVB && div_done) begin
            r_p_energy <= (adiff > (QUO_W+1)'(40'hFFFFFFFFFF)) ? 40'hFFFFFFFFFF : adiff[39:0];
        end
        if (r_state == ST_DONE && (!r_ovalid || i_m_tready)) begin
            r_o_tdata <= {r_p_energy, r_p_mwd, r_p_index};
            r_o_tlast <= r_p_last;
            r_o_tuser <= r_p_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ovalid <= 1'b0;
            r_pos    <= '0;
            r_count  <= '0;
            r_wsum   <= '0;
            r_ssum   <= '0;
            r_amp    <= '0;
            r_base   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_P3) begin
                r_amp  <= n_amp;
                r_base <= n_base;
                if (r_last) begin
                    r_pos   <= '0;
                    r_count <= '0;
                    r_wsum  <= '0;
                    r_ssum  <= '0;
                end else begin
                    r_pos   <= r_pos + PTR_W'(1);
                    r_count <= ovf ? r_count : n_len;
                    r_wsum  <= r_wsum + 28'(dx);
                    r_ssum  <= r_ssum + 52'(dm) - 52'(dold);
                end
            end
            if (r_state == ST_DONE && (!r_ovalid || i_m_tready)) begin
                r_ovalid <= 1'b1;
                if (r_p_last) begin
                    r_amp  <= '0;
                    r_base <= '0;
                end
            end else if (i_m_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_o_tdata;
    assign o_m_tlast  = r_o_tlast;
    assign o_m_tuser  = r_o_tuser;

`ifndef ASSERT_OFF
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_state == ST_P0)
        else $error("transfer did not start the sample sequence");
    a_count_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_TRACE))
        else $error("sample count beyond trace limit");
    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser) |-> (o_m_tlast && o_m_tdata[95:56] == 40'd0))
        else $error("window error with non-zero energy");
    a_div_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == ST_DIVA || r_state == ST_DIVB))
        else $error("division finished outside the energy phase");
`endif
endmodule
`default_nettype wire
